>>> rtl/core/pidtc_pkg.sv
// Package with the shared types and constants of the PID temperature controller.
package pidtc_pkg;

    // Fraction bits of the gains and of the integral sum.
    localparam int FRAC_BITS = 16;

    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] LIMIT_RAW = 64'sd10000 <<< FRAC_BITS;
    localparam logic signed [63:0] INT32_MAX_64 = 64'sd2147483647;
    localparam logic signed [63:0] INT32_MIN_64 = -64'sd2147483648;
    // Integral clamp, at most the largest 32-bit value.
    localparam logic signed [63:0] LIMIT =
        (LIMIT_RAW > INT32_MAX_64) ? INT32_MAX_64 : LIMIT_RAW;
    // An error-time product this large always drives the integral into the clamp.
    localparam logic signed [63:0] Q_CLAMP = 64'sd20000000;
    localparam logic [31:0] MS_PER_S = 32'd1000;
    localparam logic [31:0] INTERVAL_RESET = 32'd1000;

    // The integral step |q|*ONE/1000 is split into |q|*(ONE/1000) plus
    // |q|*((ONE%1000)/8)/125; the division by 125 is a reciprocal multiply
    // that is exact for every dividend below 2^32.
    localparam logic [31:0] STEP_WHOLE = 32'(ONE / 64'sd1000);
    localparam logic [31:0] STEP_FRAC8 = 32'((ONE % 64'sd1000) / 64'sd8);
    localparam logic [31:0] RECIP_125 = 32'd2199023256;
    localparam int RECIP_SHIFT = 38;

    // Configuration register indexes.
    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_GAIN_P   = 3'd0;
    localparam t_cfg_idx CFG_GAIN_I   = 3'd1;
    localparam t_cfg_idx CFG_GAIN_D   = 3'd2;
    localparam t_cfg_idx CFG_INTERVAL = 3'd3;
    localparam t_cfg_idx CFG_ENABLE   = 3'd4;

    // Request payloads.
    typedef struct packed {
        logic signed [15:0] measured_temp;
        logic signed [15:0] target_temp;
        logic [31:0]        time_ms;
    } t_pid_in;

    typedef struct packed {
        logic signed [31:0] drive;
        logic               updated;
    } t_pid_out;

endpackage

>>> rtl/core/pid_temperature_controller_top.sv
// PID temperature controller with a shared multiplier and a serial divider.
//
// Usage: an input request carries measured temperature, target and a time in ms.
// It is accepted when i_in_valid is high and o_in_stall is low. Every request
// gives exactly one result request on o_out with o_out_valid, taken when
// i_out_stall is low. Configuration uses i_cfg_we, i_cfg_idx and i_cfg_wdata
// and must be written only while the block is idle; the block does not enforce it.
// Sequence: a disabled or held request goes from idle straight to the output
// state. A full update takes six multiplier passes, a reciprocal step for the
// integral and one 64-step pass of the bit-serial divider for the derivative
// term. An integral that clamps at once skips the scale, reciprocal and sum
// steps, and zero elapsed time skips the divider.
// One request is worked on at a time; o_in_stall is high until its result is
// loaded into the output register.
// Reset (synchronous, active low) sets gains to 0, the interval to 1000 ms,
// disables the loop and clears the integral, previous error, last time and
// last drive. While the receiver stalls, the result stays in the output
// register and a finished update waits before it takes the register.
module pid_temperature_controller_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  pidtc_pkg::t_pid_in   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output pidtc_pkg::t_pid_out  o_out,
    input  logic                 i_cfg_we,
    input  pidtc_pkg::t_cfg_idx  i_cfg_idx,
    input  logic [31:0]          i_cfg_wdata
);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00_0000_0000_0001,
        S_MQ    = 14'b00_0000_0000_0010,
        S_MP    = 14'b00_0000_0000_0100,
        S_MD1   = 14'b00_0000_0000_1000,
        S_MD2   = 14'b00_0000_0001_0000,
        S_INT   = 14'b00_0000_0010_0000,
        S_SCL   = 14'b00_0000_0100_0000,
        S_REC   = 14'b00_0000_1000_0000,
        S_ISUM  = 14'b00_0001_0000_0000,
        S_MI    = 14'b00_0010_0000_0000,
        S_DTERM = 14'b00_0100_0000_0000,
        S_DIVD  = 14'b00_1000_0000_0000,
        S_FIN   = 14'b01_0000_0000_0000,
        S_OUT   = 14'b10_0000_0000_0000
    } t_state;

    localparam logic [5:0] DIV_LAST = 6'd63;

    t_state r_state;

    // Configuration and loop state.
    logic signed [31:0] r_kp, r_ki, r_kd;
    logic [31:0]        r_interval;
    logic               r_enable;
    logic signed [31:0] r_integral;
    logic signed [16:0] r_prev_err;
    logic [31:0]        r_last_time;
    logic signed [31:0] r_last_drive;

    // Working registers of one update.
    logic signed [16:0] r_err;
    logic [31:0]        r_ms;
    logic [31:0]        r_now;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_q;
    logic signed [63:0] r_pterm;
    logic signed [63:0] r_dnum;
    logic signed [63:0] r_iterm;
    logic signed [63:0] r_dterm;
    logic signed [31:0] r_sum;
    logic [24:0]        r_qabs;
    logic [31:0]        r_qz;
    logic [39:0]        r_qw;
    pidtc_pkg::t_pid_out r_res;
    pidtc_pkg::t_pid_out r_out;
    logic               r_out_valid;

    // Serial divider.
    logic [31:0] r_rem;
    logic [63:0] r_dq;
    logic [31:0] r_dvs;
    logic        r_div_neg;
    logic [5:0]  r_cnt;

    logic               in_acc;
    logic [31:0]        since;
    logic signed [16:0] in_err;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    logic [32:0]        rem_sh;
    logic               div_ge;
    logic [31:0]        n_rem;
    logic [63:0]        n_dq;
    logic signed [63:0] quo_signed;
    logic [63:0]        step_mag;
    logic signed [63:0] step_signed;
    logic signed [63:0] sum_wide;
    logic signed [31:0] sum_clamped;
    logic signed [63:0] iprod_adj;
    logic signed [63:0] total;
    logic signed [63:0] total_adj;
    logic signed [63:0] drv_wide;
    logic signed [31:0] drv_sat;
    logic signed [63:0] q_mag;
    logic signed [63:0] dnum_mag;
    logic               out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign since  = i_in.time_ms - r_last_time;
    assign in_err = 17'(i_in.target_temp) - 17'(i_in.measured_temp);

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MQ: begin
                mul_a = 34'(r_err);
                mul_b = {2'b00, r_ms};
            end
            S_MP: begin
                mul_a = 34'(r_kp);
                mul_b = 34'(r_err);
            end
            S_MD1: begin
                mul_a = 34'(r_err) - 34'(r_prev_err);
                mul_b = {2'b00, pidtc_pkg::MS_PER_S};
            end
            S_MD2: begin
                mul_a = 34'(r_kd);
                mul_b = 34'($signed(r_prod[27:0]));
            end
            S_REC: begin
                mul_a = 34'(r_qz);
                mul_b = {2'b00, pidtc_pkg::RECIP_125};
            end
            S_MI: begin
                mul_a = 34'(r_ki);
                mul_b = 34'(r_sum);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // One restoring step of the divider.
    assign rem_sh     = {r_rem, r_dq[63]};
    assign div_ge     = rem_sh >= {1'b0, r_dvs};
    assign n_rem      = div_ge ? 32'(rem_sh - {1'b0, r_dvs}) : rem_sh[31:0];
    assign n_dq       = {r_dq[62:0], div_ge};
    assign quo_signed = r_div_neg ? -$signed(n_dq) : $signed(n_dq);

    // Integral step from the whole part and the reciprocal quotient, then the clamp.
    assign step_mag    = 64'(r_qw) + 64'(r_prod[63:pidtc_pkg::RECIP_SHIFT]);
    assign step_signed = r_div_neg ? -$signed(step_mag) : $signed(step_mag);
    assign sum_wide    = 64'(r_integral) + step_signed;
    always_comb begin
        if (sum_wide > pidtc_pkg::LIMIT) begin
            sum_clamped = 32'(pidtc_pkg::LIMIT);
        end else if (sum_wide < -pidtc_pkg::LIMIT) begin
            sum_clamped = 32'(-pidtc_pkg::LIMIT);
        end else begin
            sum_clamped = sum_wide[31:0];
        end
    end

    assign q_mag    = r_q[63] ? -r_q : r_q;
    assign dnum_mag = r_dnum[63] ? -r_dnum : r_dnum;

    // Truncation toward zero of the integral term.
    assign iprod_adj = r_prod + (r_prod[63] ? (pidtc_pkg::ONE - 64'sd1) : 64'sd0);

    // Final sum, truncation toward zero and saturation.
    assign total     = r_pterm + r_iterm + r_dterm;
    assign total_adj = total + (total[63] ? (pidtc_pkg::ONE - 64'sd1) : 64'sd0);
    assign drv_wide  = total_adj >>> pidtc_pkg::FRAC_BITS;
    always_comb begin
        if (drv_wide > pidtc_pkg::INT32_MAX_64) begin
            drv_sat = 32'(pidtc_pkg::INT32_MAX_64);
        end else if (drv_wide < pidtc_pkg::INT32_MIN_64) begin
            drv_sat = 32'(pidtc_pkg::INT32_MIN_64);
        end else begin
            drv_sat = drv_wide[31:0];
        end
    end

    // Sequencer, configuration and state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_kp         <= '0;
            r_ki         <= '0;
            r_kd         <= '0;
            r_interval   <= pidtc_pkg::INTERVAL_RESET;
            r_enable     <= 1'b0;
            r_integral   <= '0;
            r_prev_err   <= '0;
            r_last_time  <= '0;
            r_last_drive <= '0;
            r_out_valid  <= 1'b0;
            r_cnt        <= '0;
        end else begin
            // The output state reloads the register itself.
            if (r_out_valid && !i_out_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pidtc_pkg::CFG_GAIN_P:   r_kp <= i_cfg_wdata;
                    pidtc_pkg::CFG_GAIN_I:   r_ki <= i_cfg_wdata;
                    pidtc_pkg::CFG_GAIN_D:   r_kd <= i_cfg_wdata;
                    pidtc_pkg::CFG_INTERVAL: r_interval <= i_cfg_wdata;
                    pidtc_pkg::CFG_ENABLE: begin
                        r_enable    <= i_cfg_wdata[0];
                        r_integral  <= '0;
                        r_prev_err  <= '0;
                        r_last_time <= '0;
                    end
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_err <= in_err;
                        r_now <= i_in.time_ms;
                        r_ms  <= (r_last_time == '0) ? pidtc_pkg::MS_PER_S : since;
                        if (!r_enable) begin
                            r_res.drive   <= '0;
                            r_res.updated <= 1'b0;
                            r_state       <= S_OUT;
                        end else if (r_last_time != '0 && since < r_interval) begin
                            r_res.drive   <= r_last_drive;
                            r_res.updated <= 1'b0;
                            r_state       <= S_OUT;
                        end else begin
                            r_state <= S_MQ;
                        end
                    end
                end
                S_MQ: begin
                    r_prod  <= mul_p[63:0];
                    r_state <= S_MP;
                end
                S_MP: begin
                    r_q     <= r_prod;
                    r_prod  <= mul_p[63:0];
                    r_state <= S_MD1;
                end
                S_MD1: begin
                    r_pterm <= r_prod;
                    r_prod  <= mul_p[63:0];
                    r_state <= S_MD2;
                end
                S_MD2: begin
                    r_prod  <= mul_p[63:0];
                    r_state <= S_INT;
                end
                S_INT: begin
                    // The integral either clamps at once or needs the scaled step.
                    r_dnum <= r_prod;
                    if (r_q >= pidtc_pkg::Q_CLAMP) begin
                        r_sum   <= 32'(pidtc_pkg::LIMIT);
                        r_state <= S_MI;
                    end else if (r_q <= -pidtc_pkg::Q_CLAMP) begin
                        r_sum   <= 32'(-pidtc_pkg::LIMIT);
                        r_state <= S_MI;
                    end else begin
                        r_qabs    <= q_mag[24:0];
                        r_div_neg <= r_q[63];
                        r_state   <= S_SCL;
                    end
                end
                S_SCL: begin
                    // Split the step into a whole part and a remainder over 125.
                    r_qz    <= 32'(r_qabs) * pidtc_pkg::STEP_FRAC8;
                    r_qw    <= 40'(r_qabs) * 40'(pidtc_pkg::STEP_WHOLE);
                    r_state <= S_REC;
                end
                S_REC: begin
                    r_prod  <= mul_p[63:0];
                    r_state <= S_ISUM;
                end
                S_ISUM: begin
                    r_sum   <= sum_clamped;
                    r_state <= S_MI;
                end
                S_MI: begin
                    r_integral <= r_sum;
                    r_prod     <= mul_p[63:0];
                    r_state    <= S_DTERM;
                end
                S_DTERM: begin
                    r_iterm <= iprod_adj >>> pidtc_pkg::FRAC_BITS;
                    if (r_ms == '0) begin
                        r_dterm <= '0;
                        r_state <= S_FIN;
                    end else begin
                        r_rem     <= '0;
                        r_dq      <= dnum_mag;
                        r_dvs     <= r_ms;
                        r_div_neg <= r_dnum[63];
                        r_cnt     <= DIV_LAST;
                        r_state   <= S_DIVD;
                    end
                end
                S_DIVD: begin
                    r_rem <= n_rem;
                    r_dq  <= n_dq;
                    if (r_cnt == '0) begin
                        r_dterm <= quo_signed;
                        r_state <= S_FIN;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                S_FIN: begin
                    r_prev_err    <= r_err;
                    r_last_time   <= r_now;
                    r_last_drive  <= drv_sat;
                    r_res.drive   <= drv_sat;
                    r_res.updated <= 1'b1;
                    r_state       <= S_OUT;
                end
                S_OUT: begin
                    // Wait until the output register can take the result.
                    if (out_free) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    // The divider counter runs only during a division.
    a_cnt_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (r_state == S_DIVD))
        else $error("divider counter active outside a division");

    // The integral sum never leaves its clamp range.
    a_integral_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (64'(r_integral) <= pidtc_pkg::LIMIT) && (64'(r_integral) >= -pidtc_pkg::LIMIT))
        else $error("integral sum outside its clamp range");

    // An accepted request always starts work.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("accepted request left the sequencer idle");

    // A result is loaded only from the final state.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("output loaded outside the output state");
`endif

endmodule
